[design/dct_pkg.sv]
// Package for the codon translate and count block.
// Holds the item types, the codon request record, and the genetic code table.
// No dependencies.
package dct_pkg;

    // Widths fixed by the item fields.
    localparam int BASE_W   = 8;
    localparam int CODON_W  = 6;
    localparam int CODE_W   = 5;
    localparam int COUNT_W  = 5;
    localparam int HITS_W   = 16;
    localparam int NUM_CODES = 22;

    // Default width of the saturating target counter.
    localparam int HIT_COUNT_WIDTH_DEF = 16;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // Special translation codes.
    localparam logic [CODE_W-1:0] CODE_STOP    = 5'd20;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 5'd21;

    // Two-bit base codes; bit 2 of a held base marks a non-ACGT character.
    localparam logic [2:0] BASE_A   = 3'd0;
    localparam logic [2:0] BASE_C   = 3'd1;
    localparam logic [2:0] BASE_G   = 3'd2;
    localparam logic [2:0] BASE_T   = 3'd3;
    localparam logic [2:0] BASE_BAD = 3'd4;

    // Input item.
    typedef struct packed {
        logic [BASE_W-1:0] base_char;
        logic              strand_end;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic               codon_valid;
        logic [CODE_W-1:0]  amino_code;
        logic [COUNT_W-1:0] distinct_count;
        logic [HITS_W-1:0]  target_hits;
        logic               strand_done;
    } t_out_item;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        logic               have_codon;
        logic               bad_base;
        logic [CODON_W-1:0] codon_idx;
        logic               last;
    } t_codon_req;

    // Standard genetic code, indexed by first base in the high bits.
    localparam logic [CODE_W-1:0] CODON_TABLE [64] = '{
        5'd18, 5'd14, 5'd18, 5'd14, 5'd9,  5'd9,  5'd9,  5'd9,
        5'd19, 5'd10, 5'd19, 5'd10, 5'd0,  5'd0,  5'd4,  5'd0,
        5'd13, 5'd15, 5'd13, 5'd15, 5'd8,  5'd8,  5'd8,  5'd8,
        5'd19, 5'd19, 5'd19, 5'd19, 5'd1,  5'd1,  5'd1,  5'd1,
        5'd16, 5'd17, 5'd16, 5'd17, 5'd6,  5'd6,  5'd6,  5'd6,
        5'd7,  5'd7,  5'd7,  5'd7,  5'd2,  5'd2,  5'd2,  5'd2,
        5'd20, 5'd11, 5'd20, 5'd11, 5'd10, 5'd10, 5'd10, 5'd10,
        5'd20, 5'd5,  5'd12, 5'd5,  5'd1,  5'd3,  5'd1,  5'd3
    };

endpackage

[design/dct_front.sv]
// Front end of the codon translate and count block.
// Accepts nucleotide items, groups bases into codons and queues requests.
// Depends on dct_pkg.
module dct_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dct_pkg::t_in_item   i_in_item,
    input  logic                i_queue_full,
    output logic                o_push,
    output dct_pkg::t_codon_req o_req
);
    import dct_pkg::*;

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic [2:0] r_held0;
    logic [2:0] r_held1;
    logic [2:0] w_base;
    logic       w_accept;
    logic       w_full_codon;

    // Map an ASCII character onto a base code.
    always_comb begin
        unique case (i_in_item.base_char)
            8'h41:   w_base = BASE_A;
            8'h43:   w_base = BASE_C;
            8'h47:   w_base = BASE_G;
            8'h54:   w_base = BASE_T;
            default: w_base = BASE_BAD;
        endcase
    end

    assign o_in_stall   = i_queue_full;
    assign w_accept     = i_in_valid && !i_queue_full;
    assign w_full_codon = (r_phase == 2'd2);

    // Only a completed codon or the last base of a strand makes a request.
    assign o_push = w_accept && (w_full_codon || i_in_item.strand_end);

    always_comb begin
        o_req.have_codon = w_full_codon;
        o_req.bad_base   = r_held0[2] | r_held1[2] | w_base[2];
        o_req.codon_idx  = {r_held0[1:0], r_held1[1:0], w_base[1:0]};
        o_req.last       = i_in_item.strand_end;
    end

    // Phase advances per base and returns to zero on a codon or strand end.
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            if (w_full_codon || i_in_item.strand_end) begin
                n_phase = 2'd0;
            end else begin
                n_phase = r_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Held bases need no reset; the phase guards every read.
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_full_codon) begin
            if (r_phase[0]) begin
                r_held1 <= w_base;
            end else begin
                r_held0 <= w_base;
            end
        end
    end

endmodule

[design/dct_queue.sv]
// Short request queue between the front and back ends.
// A small register array with read and write pointers.
// Depends on dct_pkg.
module dct_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dct_pkg::t_codon_req i_req,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_nonempty,
    output dct_pkg::t_codon_req o_req
);
    import dct_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_codon_req       r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_req      = r_slot[r_rd_ptr];

    // Pointer and fill count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_req;
        end
    end

endmodule

[design/dct_back.sv]
// Back end of the codon translate and count block.
// Translates queued codons, keeps per-strand counts and registers results.
// Depends on dct_pkg.
module dct_back #(
    parameter int HIT_COUNT_WIDTH = dct_pkg::HIT_COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dct_pkg::CODON_W-1:0] i_cfg_data,
    input  logic                       i_nonempty,
    input  dct_pkg::t_codon_req        i_req,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output dct_pkg::t_out_item         o_out_item
);
    import dct_pkg::*;

    logic [CODON_W-1:0]         r_target;
    logic [NUM_CODES-1:0]       r_seen;
    logic [NUM_CODES-1:0]       n_seen;
    logic [COUNT_W-1:0]         r_distinct;
    logic [COUNT_W-1:0]         n_distinct;
    logic [HIT_COUNT_WIDTH-1:0] r_hits;
    logic [HIT_COUNT_WIDTH-1:0] n_hits;
    logic                       r_out_valid;
    t_out_item                  r_out_item;
    t_out_item                  n_out_item;
    logic [CODE_W-1:0]          w_code;
    logic                       w_new_code;
    logic                       w_match;
    logic [HIT_COUNT_WIDTH+HITS_W-1:0] w_hits_ext;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_data;
        end
    end

    // Take the next request whenever the output register is free or draining.
    assign o_pop = i_nonempty && (!r_out_valid || !i_out_stall);

    // Translate the codon and update the strand counts.
    always_comb begin
        if (!i_req.have_codon) begin
            w_code = '0;
        end else if (i_req.bad_base) begin
            w_code = CODE_UNKNOWN;
        end else begin
            w_code = CODON_TABLE[i_req.codon_idx];
        end
        w_new_code = i_req.have_codon && !r_seen[w_code];
        w_match    = i_req.have_codon && !i_req.bad_base && (i_req.codon_idx == r_target);

        n_seen = r_seen;
        if (i_req.have_codon) begin
            n_seen[w_code] = 1'b1;
        end
        n_distinct = r_distinct + COUNT_W'(w_new_code);
        n_hits     = r_hits;
        if (w_match && (r_hits != {HIT_COUNT_WIDTH{1'b1}})) begin
            n_hits = r_hits + 1'b1;
        end

        w_hits_ext = {{HITS_W{1'b0}}, n_hits};

        n_out_item.codon_valid    = i_req.have_codon;
        n_out_item.amino_code     = w_code;
        n_out_item.distinct_count = n_distinct;
        n_out_item.target_hits    = w_hits_ext[HITS_W-1:0];
        n_out_item.strand_done    = i_req.last;
    end

    // Strand state; the last base of a strand clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_distinct <= '0;
            r_hits     <= '0;
        end else if (o_pop) begin
            if (i_req.last) begin
                r_seen     <= '0;
                r_distinct <= '0;
                r_hits     <= '0;
            end else begin
                r_seen     <= n_seen;
                r_distinct <= n_distinct;
                r_hits     <= n_hits;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[design/dna_codon_translate_count.sv]
// Top level of the codon translate and count block.
// Connects the front end, the request queue and the back end.
// Depends on dct_pkg, dct_front, dct_queue, dct_back.
//
//   Channel   Direction  Handshake               Payload
//   in        input      i_in_valid / o_in_stall i_in_item  (t_in_item)
//   out       output     o_out_valid/i_out_stall o_out_item (t_out_item)
//   cfg       input      i_cfg_we                i_cfg_data (target codon)
//
// One nucleotide item is taken every cycle while o_in_stall is low. The request
// for an item is held in the request queue and its result in the output register.
// Reset is synchronous and clears the phase, the queue, the counts and the
// target codon. o_in_stall rises only when the two-entry queue is full, which
// happens when the output side holds its stall.
module dna_codon_translate_count #(
    parameter int HIT_COUNT_WIDTH = dct_pkg::HIT_COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dct_pkg::CODON_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dct_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output dct_pkg::t_out_item          o_out_item
);
    import dct_pkg::*;

    t_codon_req w_push_req;
    t_codon_req w_head_req;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_nonempty;

    // Base grouping and classification.
    dct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_req        (w_push_req)
    );

    // Decoupling queue.
    dct_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_req      (w_push_req),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_req      (w_head_req)
    );

    // Translation, counting and result register.
    dct_back #(
        .HIT_COUNT_WIDTH (HIT_COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_nonempty  (w_nonempty),
        .i_req       (w_head_req),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[design/dct_checker.sv]
// Port-level checks for the codon translate and count block.
// Bound to the top level; depends on dct_pkg and dna_codon_translate_count.
module dct_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [dct_pkg::CODON_W-1:0] i_cfg_data,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input dct_pkg::t_in_item           i_in_item,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input dct_pkg::t_out_item          o_out_item
);
    import dct_pkg::*;

    // A stalled result stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // A result without a codon is only the end-of-strand result, with code zero.
    a_no_codon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.codon_valid |->
            o_out_item.strand_done && (o_out_item.amino_code == '0))
        else $error("result without codon is not a strand end");

    // A translated codon has a code in range and counts at least itself.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.codon_valid |->
            (o_out_item.amino_code <= CODE_UNKNOWN) &&
            (o_out_item.distinct_count != '0))
        else $error("bad code or distinct count");

    // The distinct count never exceeds the number of codes.
    a_distinct_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.distinct_count <= COUNT_W'(NUM_CODES))
        else $error("distinct count out of range");

endmodule

bind dna_codon_translate_count dct_checker u_dct_checker (.*);
